// ===== sv/icmp_rw_pkg.sv =====
// shared constants, types and helpers for the icmp echo reply rewriter
package icmp_rw_pkg;

  // default depth of the header buffer in 16-bit words
  localparam int HDR_WORDS_DEF = 37;

  // field and counter widths
  localparam int WORD_W  = 16;
  localparam int BYTES_W = 2;
  localparam int IDX_W   = 6;
  localparam int IHL_W   = 4;
  // 30 summed words of 16 bits fit in 22 bits
  localparam int ACC_W   = 22;

  // icmp type codes
  localparam logic [7:0] ECHO_REQUEST = 8'h08;
  localparam logic [7:0] ECHO_REPLY   = 8'h00;

  // word positions within the frame
  localparam logic [IDX_W-1:0] FIRST_DEC     = 6'd17;
  localparam logic [IDX_W-1:0] IHL_IDX       = 6'd7;
  localparam logic [IDX_W-1:0] CSUM_IDX      = 6'd12;
  localparam logic [IDX_W-1:0] TYPE_IDX      = 6'd17;
  localparam logic [IDX_W-1:0] MAC_SRC_IDX   = 6'd3;
  localparam logic [IDX_W-1:0] IP_SRC_IDX    = 6'd13;
  localparam logic [IDX_W-1:0] IP_DST_IDX    = 6'd15;
  localparam logic [IDX_W-1:0] MAC_WORDS     = 6'd3;
  localparam logic [IDX_W-1:0] IP_ADDR_WORDS = 6'd2;
  localparam logic [IDX_W-1:0] DEC_BASE      = 6'd6;

  // byte count codes
  localparam logic [BYTES_W-1:0] BYTES_ONE = 2'd1;
  localparam logic [BYTES_W-1:0] BYTES_TWO = 2'd2;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DROP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_FORWARD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic hdr_wr;
    logic idx_clr;
    logic idx_inc;
    logic emit_start;
    logic rd_en;
    logic out_hdr;
    logic out_fwd;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic past_first;
    logic too_long;
    logic at_dec;
    logic echo;
    logic emit_done;
    logic emit_last;
    logic out_free;
  } sts_t;

  // buffer word that lands at reply position k (mac and ip address swap)
  function automatic logic [IDX_W-1:0] src_index(input logic [IDX_W-1:0] k);
    logic [IDX_W-1:0] s;
    s = k;
    if (k < MAC_SRC_IDX) begin
      s = k + MAC_SRC_IDX;
    end else if (k < MAC_SRC_IDX + MAC_WORDS) begin
      s = k - MAC_SRC_IDX;
    end else if (k >= IP_SRC_IDX && k < IP_DST_IDX) begin
      s = k + IP_ADDR_WORDS;
    end else if (k >= IP_DST_IDX && k < IP_DST_IDX + IP_ADDR_WORDS) begin
      s = k - IP_ADDR_WORDS;
    end
    return s;
  endfunction

endpackage

// ===== sv/icmp_rw_ram.sv =====
// generic single-port-write, registered-read ram
module icmp_rw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 37,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/icmp_rw_dp.sv =====
// datapath: header buffer, checksum accumulator, reply counter and output register
module icmp_rw_dp #(
  parameter int HDR_WORDS = icmp_rw_pkg::HDR_WORDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  icmp_rw_pkg::cmd_t                   cmd,
  output icmp_rw_pkg::sts_t                   sts,
  input  logic [icmp_rw_pkg::WORD_W-1:0]      in_word,
  input  logic [icmp_rw_pkg::BYTES_W-1:0]     in_bytes,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [icmp_rw_pkg::WORD_W-1:0]      out_word,
  output logic [icmp_rw_pkg::BYTES_W-1:0]     out_bytes,
  output logic                                out_last
);
  import icmp_rw_pkg::*;

  localparam int AW = (HDR_WORDS > 1) ? $clog2(HDR_WORDS) : 1;
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(HDR_WORDS);
  localparam logic [IDX_W-1:0] MAX_DEC   = IDX_W'(HDR_WORDS - 1);

  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IHL_W-1:0]   hl_r;
  logic [ACC_W-1:0]   acc_r;
  logic               echo_r;
  logic [IDX_W-1:0]   k_r;
  logic [IDX_W-1:0]   d_r;
  logic [BYTES_W-1:0] nb_r;
  logic               last_r;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r;
  logic [BYTES_W-1:0] out_bytes_r;
  logic               out_last_r;

  logic [IHL_W-1:0]   hl_eff;
  logic [IDX_W-1:0]   sum_end;
  logic [IDX_W-1:0]   sum_pos;
  logic               in_sum;
  logic [WORD_W-1:0]  add_word;
  logic [IDX_W-1:0]   dec_raw;
  logic [IDX_W-1:0]   dec_idx;
  logic [BYTES_W-1:0] in_nb;
  logic [IDX_W-1:0]   src_idx;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W:0]    fold1;
  logic [WORD_W-1:0]  fold2;
  logic [WORD_W-1:0]  csum;
  logic [WORD_W-1:0]  hdr_word;
  logic               is_dec_word;

  // checksum window: reply positions 7 .. 6+2*ihl, ihl taken live at word 7
  // an incoming word is counted at the position it lands on after the address swap
  assign hl_eff   = (idx_r == IHL_IDX) ? in_word[11:8] : hl_r;
  assign sum_end  = IHL_IDX + {1'b0, hl_eff, 1'b0};
  assign sum_pos  = src_index(idx_r);
  assign in_sum   = (sum_pos >= IHL_IDX) && (sum_pos < sum_end);

  // checksum field counts as zero, type byte counts as cleared
  always_comb begin
    if (idx_r == CSUM_IDX) begin
      add_word = '0;
    end else if (idx_r == TYPE_IDX) begin
      add_word = {ECHO_REPLY, in_word[7:0]};
    end else begin
      add_word = in_word;
    end
  end

  // decision word max(17, 6 + 2*ihl)
  assign dec_raw = DEC_BASE + {1'b0, hl_r, 1'b0};
  assign dec_idx = (dec_raw < FIRST_DEC) ? FIRST_DEC : dec_raw;

  assign in_nb = (in_bytes == BYTES_ONE) ? BYTES_ONE : BYTES_TWO;

  // status toward the controller
  assign sts.past_first = (idx_r >= FIRST_DEC);
  assign sts.too_long   = (dec_idx > MAX_DEC);
  assign sts.at_dec     = (idx_r == dec_idx);
  assign sts.echo       = (idx_r == TYPE_IDX) ? (in_word[15:8] == ECHO_REQUEST) : echo_r;
  assign sts.emit_done  = (k_r == d_r);
  assign sts.emit_last  = last_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // header buffer
  assign src_idx = src_index(k_r);

  icmp_rw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HDR_WORDS),
    .AW    (AW)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (cmd.hdr_wr && (idx_r < DEPTH_IDX)),
    .wr_addr (idx_r[AW-1:0]),
    .wr_data (in_word),
    .rd_en   (cmd.rd_en),
    .rd_addr (src_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // end-around carry fold and complement
  assign fold1 = {1'b0, acc_r[WORD_W-1:0]} + (WORD_W+1)'(acc_r[ACC_W-1:WORD_W]);
  assign fold2 = fold1[WORD_W-1:0] + WORD_W'(fold1[WORD_W]);
  assign csum  = ~fold2;

  // reply header word with checksum and type rewritten
  always_comb begin
    if (k_r == CSUM_IDX) begin
      hdr_word = csum;
    end else if (k_r == TYPE_IDX) begin
      hdr_word = {ECHO_REPLY, rd_data[7:0]};
    end else begin
      hdr_word = rd_data;
    end
  end
  assign is_dec_word = (k_r == d_r);

  // word index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      hl_r  <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.hdr_wr && idx_r == IHL_IDX) begin
        hl_r <= in_word[11:8];
      end
    end
  end

  // per-frame header bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.hdr_wr) begin
      if (idx_r == TYPE_IDX) begin
        echo_r <= (in_word[15:8] == ECHO_REQUEST);
      end
      if (idx_r == '0) begin
        acc_r <= '0;
      end else if (in_sum) begin
        acc_r <= acc_r + ACC_W'(add_word);
      end
    end
    if (cmd.emit_start) begin
      d_r    <= dec_idx;
      nb_r   <= in_nb;
      last_r <= in_last;
      k_r    <= '0;
    end else if (cmd.out_hdr) begin
      k_r <= k_r + 1'b1;
    end
  end

  // output register
  always_comb begin
    if (cmd.out_hdr || cmd.out_fwd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_hdr) begin
      out_word_r  <= hdr_word;
      out_bytes_r <= is_dec_word ? nb_r : BYTES_TWO;
      out_last_r  <= is_dec_word ? last_r : 1'b0;
    end else if (cmd.out_fwd) begin
      out_word_r  <= in_word;
      out_bytes_r <= in_nb;
      out_last_r  <= in_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_bytes = out_bytes_r;
  assign out_last  = out_last_r;

endmodule

// ===== sv/icmp_rw_ctrl.sv =====
// controller: frame state machine that sequences collect, reply and forward
module icmp_rw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  icmp_rw_pkg::sts_t   sts,
  output icmp_rw_pkg::cmd_t   cmd,
  output icmp_rw_pkg::state_t state
);
  import icmp_rw_pkg::*;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_fire = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_fire) begin
          if (sts.past_first && sts.too_long) begin
            state_nxt = in_last ? ST_COLLECT : ST_DROP;
          end else if (sts.past_first && sts.at_dec) begin
            if (!sts.echo) begin
              state_nxt = in_last ? ST_COLLECT : ST_DROP;
            end else begin
              state_nxt = ST_EMIT_RD;
            end
          end
        end
      end
      ST_DROP: begin
        if (in_fire && in_last) begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) begin
          if (!sts.emit_done) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = sts.emit_last ? ST_COLLECT : ST_FORWARD;
          end
        end
      end
      ST_FORWARD: begin
        if (in_fire && in_last) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        in_ready   = 1'b1;
        cmd.hdr_wr = in_fire;
        if (in_fire) begin
          if (sts.past_first && (sts.too_long || sts.at_dec)) begin
            cmd.idx_clr    = 1'b1;
            cmd.emit_start = !sts.too_long && sts.echo;
          end else if (in_last) begin
            cmd.idx_clr = 1'b1;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_DROP: begin
        in_ready = 1'b1;
      end
      ST_EMIT_RD: begin
        cmd.rd_en = 1'b1;
      end
      ST_EMIT_LD: begin
        cmd.out_hdr = sts.out_free;
      end
      ST_FORWARD: begin
        in_ready    = sts.out_free;
        cmd.out_fwd = in_fire;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

// ===== sv/icmp_echo_reply_rewriter.sv =====
// top level of the icmp echo reply rewriter
//
// Input channel (in_*): one ethernet frame as big-endian 16-bit words, one
// transfer per word, in_last on the final word. Output channel (out_*): the
// echo reply frame in the same format. Frames whose icmp type is not echo
// request, or that end before the decision word D = max(17, 6 + 2*IHL),
// produce no output at all.
// Header words are written into a buffer ram at one word per cycle. Once word
// D is taken, input stalls while the reply header (D+1 words) is read back
// with mac and ip addresses swapped, type cleared and a fresh ip checksum:
// each header word takes a ram read state, then an output load state that
// waits for a free output register. After that the rest of the frame passes
// through the output register at one word per cycle while out_ready allows.
// A stall on out_ready holds the output register; during forwarding it stalls
// the input, during header collection the input keeps flowing.
// Reset returns to header collection with an empty output register; buffer
// contents are not cleared and are never read before being written.
module icmp_echo_reply_rewriter #(
  parameter int HDR_WORDS = icmp_rw_pkg::HDR_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [icmp_rw_pkg::WORD_W-1:0]   in_word,
  input  logic [icmp_rw_pkg::BYTES_W-1:0]  in_bytes,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [icmp_rw_pkg::WORD_W-1:0]   out_word,
  output logic [icmp_rw_pkg::BYTES_W-1:0]  out_bytes,
  output logic                             out_last
);
  import icmp_rw_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  // frame sequencer
  icmp_rw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // buffer, checksum and output register
  icmp_rw_dp #(
    .HDR_WORDS (HDR_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .in_bytes  (in_bytes),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .out_bytes (out_bytes),
    .out_last  (out_last)
  );

  // input is held off while the reply header is read out
  a_no_input_during_reply: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state == ST_EMIT_RD || state == ST_EMIT_LD) |-> !in_ready
  ) else $error("input accepted while reply header is being sent");

  // output words only appear from header readout or forwarding
  a_out_load_source: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state == ST_EMIT_LD || state == ST_FORWARD)
  ) else $error("output loaded outside readout or forwarding");

  // after the closing transfer of a reply the block is not forwarding
  a_last_ends_frame: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (state != ST_FORWARD)
  ) else $error("still forwarding after the final reply word");

endmodule
